// ===== hw/rtl/npcs_pkg.sv =====
package npcs_pkg;

	localparam int IDX_W   = 8;
	localparam int CH_W    = 8;
	localparam int COLOR_W = 3 * CH_W;
	localparam int SQ_W    = 2 * CH_W;
	localparam int DIST_W  = SQ_W + 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
	} npcs_tag_t;

endpackage

// ===== hw/rtl/npcs_palette_mem.sv =====
module npcs_palette_mem import npcs_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [COLOR_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [COLOR_W-1:0] rdata
);

	logic [COLOR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/npcs_dist_unit.sv =====
module npcs_dist_unit import npcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               kill,
	input  npcs_tag_t          tag_s1,
	input  logic [COLOR_W-1:0] entry_s1,
	input  logic [CH_W-1:0]    qr,
	input  logic [CH_W-1:0]    qg,
	input  logic [CH_W-1:0]    qb,
	output npcs_tag_t          tag_s4,
	output logic [DIST_W-1:0]  dist_s4
);

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
	                                             input logic [CH_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	logic             valid_s2, valid_s3, valid_s4;
	logic             last_s2, last_s3, last_s4;
	logic [IDX_W-1:0] idx_s2, idx_s3, idx_s4;
	logic [CH_W-1:0]  dr_s2, dg_s2, db_s2;
	logic [SQ_W-1:0]  sr_s3, sg_s3, sb_s3;

	assign tag_s4 = {valid_s4, last_s4, idx_s4};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (kill) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= tag_s1.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		last_s2 <= tag_s1.last;
		idx_s2  <= tag_s1.idx;
		dr_s2 <= abs_diff(qr, entry_s1[3*CH_W-1:2*CH_W]);
		dg_s2 <= abs_diff(qg, entry_s1[2*CH_W-1:CH_W]);
		db_s2 <= abs_diff(qb, entry_s1[CH_W-1:0]);

		last_s3 <= last_s2;
		idx_s3  <= idx_s2;
		sr_s3 <= dr_s2 * dr_s2;
		sg_s3 <= dg_s2 * dg_s2;
		sb_s3 <= db_s2 * db_s2;

		last_s4 <= last_s3;
		idx_s4  <= idx_s3;
		dist_s4 <= DIST_W'(sr_s3) + DIST_W'(sg_s3) + DIST_W'(sb_s3);
	end

endmodule

// ===== hw/rtl/nearest_palette_color_search_unit.sv =====
// channel   dir  transfer condition     fields
// command   in   start && !busy         command, entry_index, red, green, blue
// result    out  done (one cycle)       best_index
//
// a write never raises busy
// a query scans one palette entry per cycle through the memory read and a
// three-stage distance pipeline; an exact match ends the scan early
// done comes in the cycle busy falls; the receiver cannot stall
// reset clears the sequencer and pipeline valids, not the palette
module nearest_palette_color_search_unit import npcs_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             command,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	output logic             done,
	output logic [IDX_W-1:0] best_index
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]         state_q;
	logic [AW-1:0]      addr_q;
	logic [CH_W-1:0]    qr_q, qg_q, qb_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               done_q;
	logic [IDX_W-1:0]   best_index_q;

	npcs_tag_t          tag_s1, tag_s4;
	logic               valid_s1, last_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COLOR_W-1:0] entry_s1;
	logic [DIST_W-1:0]  dist_s4;

	logic accept, query_go, wr_en, issue, last_addr, better, finish;
	logic [IDX_W-1:0] pick_idx;

	assign tag_s1    = {valid_s1, last_s1, idx_s1};
	assign accept    = start && !busy;
	assign query_go  = accept && (command == CMD_QUERY);
	assign wr_en     = accept && (command == CMD_WRITE) &&
	                   ({1'b0, entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));
	assign issue     = (state_q == ST_SCAN);
	assign last_addr = (addr_q == AW'(PALETTE_ENTRIES - 1));
	assign better    = (tag_s4.idx == '0) || (dist_s4 < best_dist_q);
	assign finish    = tag_s4.valid && ((dist_s4 == '0) || tag_s4.last);
	assign pick_idx  = better ? tag_s4.idx : best_idx_q;

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign best_index = best_index_q;

	npcs_palette_mem #(
		.DEPTH(PALETTE_ENTRIES),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (wr_en),
		.waddr(entry_index[AW-1:0]),
		.wdata({red, green, blue}),
		.raddr(addr_q),
		.rdata(entry_s1)
	);

	npcs_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.kill    (finish),
		.tag_s1  (tag_s1),
		.entry_s1(entry_s1),
		.qr      (qr_q),
		.qg      (qg_q),
		.qb      (qb_q),
		.tag_s4  (tag_s4),
		.dist_s4 (dist_s4)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			addr_q   <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= finish;
			valid_s1 <= issue && !finish;
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (query_go) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (last_addr) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		last_s1 <= last_addr;
		idx_s1  <= IDX_W'(addr_q);
		if (query_go) begin
			qr_q <= red;
			qg_q <= green;
			qb_q <= blue;
		end
		if (tag_s4.valid && better) begin
			best_dist_q <= dist_s4;
			best_idx_q  <= tag_s4.idx;
		end
		if (finish) begin
			best_index_q <= pick_idx;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still scanning");

	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a scan");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_go |=> busy)
		else $error("query transfer did not start a scan");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s4.valid |-> busy)
		else $error("distance pipeline active while idle");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import npcs_pkg::*;

	localparam int PALETTE_ENTRIES = 256;
	localparam int RANDOM_ITEMS    = 920;
	localparam int CYCLE_LIMIT     = 3_000_000;

	class palette_scoreboard;
		logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
		logic [IDX_W-1:0]   expected_best [$];
		int                 errors;

		function new();
			errors = 0;
			foreach (palette[i]) palette[i] = '0;
		endfunction

		function int channel_sq(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
			int d;
			d = int'(a) - int'(b);
			return d * d;
		endfunction

		// first strictly closest entry, scan stops on an exact hit
		function logic [IDX_W-1:0] nearest_entry(input logic [CH_W-1:0] r,
				input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
			int best;
			int best_dist;
			int d;
			best = 0;
			best_dist = 0;
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				d = channel_sq(r, palette[i][23:16]) + channel_sq(g, palette[i][15:8])
					+ channel_sq(b, palette[i][7:0]);
				if (i == 0 || d < best_dist) begin
					best = i;
					best_dist = d;
				end
				if (d == 0)
					break;
			end
			return best[IDX_W-1:0];
		endfunction

		function void note_command(input logic cmd, input logic [IDX_W-1:0] idx,
				input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
				input logic [CH_W-1:0] b);
			if (cmd == CMD_WRITE) begin
				if (idx < PALETTE_ENTRIES)
					palette[idx] = {r, g, b};
			end else begin
				expected_best.push_back(nearest_entry(r, g, b));
			end
		endfunction

		function void check_best_index(input logic [IDX_W-1:0] actual);
			logic [IDX_W-1:0] want;
			if (expected_best.size() == 0) begin
				$error("best_index: unexpected result, expected none, actual %0d", actual);
				errors++;
				return;
			end
			want = expected_best.pop_front();
			if (actual !== want) begin
				$error("best_index: expected %0d, actual %0d", want, actual);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             command;
	logic [IDX_W-1:0] entry_index;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             done;
	logic [IDX_W-1:0] best_index;

	palette_scoreboard sb;
	int                cycle_count;
	int                items_sent;
	int                burst_left;

	nearest_palette_color_search_unit #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.entry_index(entry_index),
		.red(red),
		.green(green),
		.blue(blue),
		.done(done),
		.best_index(best_index)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_best_index(best_index);
			if (start && !busy)
				sb.note_command(command, entry_index, red, green, blue);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nearest_palette_color_search_unit regression: fail");
			$finish;
		end
	end

	// sender bursts: idle gaps of varied length between bursts of items, each sent once the unit is idle
	task automatic pace();
		int gap;
		int pick;
		burst_left--;
		if (burst_left <= 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				gap = $urandom_range(1, 3);
			else if (pick < 90)
				gap = $urandom_range(4, 40);
			else
				gap = $urandom_range(41, 300);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
			input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		start       <= 1'b1;
		command     <= cmd;
		entry_index <= idx;
		red         <= r;
		green       <= g;
		blue        <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		pace();
	endtask

	task automatic write_entry(input int idx, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		send_item(CMD_WRITE, idx[IDX_W-1:0], r, g, b);
	endtask

	task automatic query_color(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		send_item(CMD_QUERY, IDX_W'($urandom_range(0, 255)), r, g, b);
	endtask

	task automatic query_entry(input int idx, input int jitter);
		logic [COLOR_W-1:0] c;
		int                 ch [3];
		c = sb.palette[idx];
		ch[0] = int'(c[23:16]);
		ch[1] = int'(c[15:8]);
		ch[2] = int'(c[7:0]);
		foreach (ch[k]) begin
			ch[k] += int'($urandom_range(0, 2 * jitter)) - jitter;
			if (ch[k] < 0)
				ch[k] = 0;
			if (ch[k] > 255)
				ch[k] = 255;
		end
		query_color(CH_W'(ch[0]), CH_W'(ch[1]), CH_W'(ch[2]));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_best.size() != 0) @(posedge clk);
	endtask

	function automatic logic [CH_W-1:0] pick_channel(input int mode);
		int coarse [6] = '{0, 1, 127, 128, 254, 255};
		if (mode == 0)
			return CH_W'($urandom_range(0, 255));
		else if (mode == 1)
			return CH_W'(coarse[$urandom_range(0, 5)]);
		else
			return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
	endfunction

	initial begin
		int  kind;
		int  idx;
		int  mode;
		bit  rewritten;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;

		sb          = new();
		cycle_count = 0;
		items_sent  = 0;
		burst_left  = 4;
		rewritten   = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		command     = CMD_WRITE;
		entry_index = '0;
		red         = '0;
		green       = '0;
		blue        = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole palette black so no query reads an unwritten entry
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			write_entry(i, 8'h00, 8'h00, 8'h00);

		query_color(8'hff, 8'hff, 8'hff);
		query_color(8'h00, 8'h00, 8'h00);
		write_entry(255, 8'hff, 8'hff, 8'hff);
		query_color(8'hff, 8'hff, 8'hff);
		write_entry(0, 8'hff, 8'h00, 8'h00);
		query_color(8'h00, 8'h00, 8'h00);
		write_entry(7, 8'h00, 8'h00, 8'hff);
		write_entry(3, 8'h00, 8'h00, 8'hff);
		query_color(8'h00, 8'h00, 8'hfa);
		write_entry(100, 8'd12, 8'd34, 8'd56);
		query_color(8'd13, 8'd35, 8'd57);
		query_color(8'hff, 8'hff, 8'hfe);
		write_entry(254, 8'hff, 8'hff, 8'hff);
		query_color(8'hff, 8'hff, 8'hff);
		send_item(CMD_QUERY, 8'hff, 8'h00, 8'hff, 8'h00);
		send_item(CMD_QUERY, 8'h00, 8'd128, 8'd128, 8'd128);
		query_color(8'h00, 8'hff, 8'hff);
		wait_idle();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (!rewritten && items_sent >= RANDOM_ITEMS / 2) begin
				// eight-color palette: many equally close entries
				wait_idle();
				for (int i = 0; i < PALETTE_ENTRIES; i++)
					write_entry(i, pick_channel(2), pick_channel(2), pick_channel(2));
				rewritten = 1;
				wait_idle();
			end
			if ($urandom_range(0, 199) == 0)
				wait_idle();
			kind = $urandom_range(0, 99);
			mode = $urandom_range(0, 2);
			idx  = $urandom_range(0, PALETTE_ENTRIES - 1);
			r    = pick_channel(mode);
			g    = pick_channel(mode);
			b    = pick_channel(mode);
			if (kind < 25) begin
				write_entry(idx, r, g, b);
			end else if (kind < 40) begin
				write_entry(idx, r, g, b);
				query_color(r, g, b);
			end else if (kind < 60) begin
				query_entry(idx, 0);
			end else if (kind < 75) begin
				query_entry(idx, $urandom_range(1, 4));
			end else if (kind < 90) begin
				query_color(pick_channel(0), pick_channel(0), pick_channel(0));
			end else begin
				query_color(pick_channel(2), pick_channel(2), pick_channel(2));
			end
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (sb.expected_best.size() != 0) begin
			$error("best_index: %0d results never arrived", sb.expected_best.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("nearest_palette_color_search_unit regression: pass");
		else
			$display("nearest_palette_color_search_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_palette_mem.sv
hw/rtl/npcs_dist_unit.sv
hw/rtl/nearest_palette_color_search_unit.sv
tb/tb_top.sv
